>>> src/dual_stack_shared_memory_macros.svh
// Assertion macros for the dual stack block.
// Each macro expects clk and rst_n to be in scope at the point of use.
`ifndef DUAL_STACK_SHARED_MEMORY_MACROS_SVH
`define DUAL_STACK_SHARED_MEMORY_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define DSSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define DSSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dssm_pkg.sv
// Shared types and constants for the dual stack block.
// No dependencies; dssm_ctrl, dssm_datapath, the top level and the testbench import it.
`timescale 1ns / 1ps

package dssm_pkg;

  // Field widths of the beats.
  localparam int OPCODE_W    = 3;
  localparam int WORD_W      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Operation codes carried in the lowest bits of the input beat.
  typedef enum logic [OPCODE_W-1:0] {
    OP_LPUSH = 3'd0,
    OP_LPOP  = 3'd1,
    OP_RPUSH = 3'd2,
    OP_RPOP  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // An input beat is taken this cycle.
    logic load_read;  // Memory read data is valid and goes to the result.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_pop;     // The offered beat is a pop that succeeds.
  } dp_stat_t;

endpackage

>>> src/dssm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle: write when enabled, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/dssm_ctrl.sv
// Controller for the dual stack block: accepts beats and owns the result slot.
// Depends on dssm_pkg.
`timescale 1ns / 1ps

module dssm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                out_tready,
  input  dssm_pkg::dp_stat_t  stat,
  output logic                in_tready,
  output logic                out_tvalid,
  output dssm_pkg::ctrl_cmd_t cmd
);

  import dssm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;
  logic   load_read;

  // A beat may enter when the result slot is empty or emptying this cycle.
  assign slot_free = !out_valid_r || out_tready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && stat.rd_pop) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    in_tready = 1'b0;
    load_read = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = slot_free;
      end
      ST_READ: begin
        load_read = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept        = in_tvalid && in_tready;
  assign cmd.accept    = accept;
  assign cmd.load_read = load_read;

  // Successful pops fill the slot from the read state; all else on acceptance.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((accept && !stat.rd_pop) || load_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> src/dssm_datapath.sv
// Datapath for the dual stack block: stack tops, shared word memory, result.
// Depends on dssm_pkg and dssm_ram.
`timescale 1ns / 1ps

module dssm_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dssm_pkg::OPCODE_W-1:0] opcode,
  input  logic [dssm_pkg::WORD_W-1:0]   push_value,
  input  dssm_pkg::ctrl_cmd_t           cmd,
  output dssm_pkg::dp_stat_t            stat,
  output logic                          ok,
  output logic [dssm_pkg::WORD_W-1:0]   pop_value
);

  import dssm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     left_count_r, left_count_nxt;
  logic [CW-1:0]     right_base_r, right_base_nxt;
  logic [CW-1:0]     idx;
  logic [AW-1:0]     addr;
  logic              wr_req;
  logic              ok_c;
  logic              rd_pop;
  logic [WORD_W-1:0] rdata;
  logic              ok_r;
  logic [WORD_W-1:0] pop_r;

  // Decode the offered operation against the current stack tops.
  always_comb begin
    left_count_nxt = left_count_r;
    right_base_nxt = right_base_r;
    idx            = left_count_r;
    addr           = left_count_r[AW-1:0];
    wr_req         = 1'b0;
    ok_c           = 1'b0;
    rd_pop         = 1'b0;
    case (op_t'(opcode))
      OP_LPUSH: begin
        if (left_count_r < right_base_r) begin
          wr_req         = 1'b1;
          addr           = left_count_r[AW-1:0];
          left_count_nxt = left_count_r + CW'(1);
          ok_c           = 1'b1;
        end
      end
      OP_LPOP: begin
        if (left_count_r != '0) begin
          idx            = left_count_r - CW'(1);
          addr           = idx[AW-1:0];
          left_count_nxt = idx;
          ok_c           = 1'b1;
          rd_pop         = 1'b1;
        end
      end
      OP_RPUSH: begin
        if (right_base_r > left_count_r) begin
          idx            = right_base_r - CW'(1);
          wr_req         = 1'b1;
          addr           = idx[AW-1:0];
          right_base_nxt = idx;
          ok_c           = 1'b1;
        end
      end
      OP_RPOP: begin
        if (right_base_r < CW'(DEPTH)) begin
          addr           = right_base_r[AW-1:0];
          right_base_nxt = right_base_r + CW'(1);
          ok_c           = 1'b1;
          rd_pop         = 1'b1;
        end
      end
      OP_CLEAR: begin
        left_count_nxt = '0;
        right_base_nxt = CW'(DEPTH);
        ok_c           = 1'b1;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  assign stat.rd_pop = rd_pop;

  // Stack tops move only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_count_r <= '0;
      right_base_r <= CW'(DEPTH);
    end else if (cmd.accept) begin
      left_count_r <= left_count_nxt;
      right_base_r <= right_base_nxt;
    end
  end

  // Shared word store for both stacks.
  dssm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.accept && wr_req),
    .addr  (addr),
    .wdata (push_value),
    .rdata (rdata)
  );

  // Result register: immediate for non-pops and failed pops, memory data for successful pops.
  always_ff @(posedge clk) begin
    if (cmd.accept && !rd_pop) begin
      ok_r  <= ok_c;
      pop_r <= '0;
    end else if (cmd.load_read) begin
      ok_r  <= 1'b1;
      pop_r <= rdata;
    end
  end

  assign ok        = ok_r;
  assign pop_value = pop_r;

endmodule

>>> src/dual_stack_shared_memory.sv
// Top level of the dual stack block: two LIFO stacks in one word memory.
// Depends on dssm_pkg, dssm_ctrl, dssm_datapath and the assertion macro header.
//
//   Channel  Direction  Beat contents (lowest bit first)
//   in_      slave      opcode[2:0], push_value[34:3], zero pad to 40 bits
//   out_     master     ok[0], pop_value[32:1], zero pad to 40 bits
//
// Push, clear and failed pops can enter back to back; after a successful pop,
// the read state takes no beat while the single port's registered read returns.
// A new beat is taken while a finished result still waits, provided the
// result register is free by the next edge. Reset empties both stacks and
// the result register; the memory contents are not cleared.
`timescale 1ns / 1ps
`include "dual_stack_shared_memory_macros.svh"

module dual_stack_shared_memory #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // opcode[2:0], push_value[34:3], zeros above
  input  logic [dssm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // ok[0], pop_value[32:1], zeros above
  output logic [dssm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import dssm_pkg::*;

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic              ok;
  logic [WORD_W-1:0] pop_value;

  // Controller.
  dssm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // Datapath.
  dssm_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .opcode     (in_tdata[OPCODE_W-1:0]),
    .push_value (in_tdata[OPCODE_W+WORD_W-1:OPCODE_W]),
    .cmd        (cmd),
    .stat       (stat),
    .ok         (ok),
    .pop_value  (pop_value)
  );

  // Pack the result beat.
  assign out_tdata = {{(OUT_TDATA_W-WORD_W-1){1'b0}}, pop_value, ok};

  // A memory read result only follows an accepted pop.
  `DSSM_ASSERT_IMP(a_read_after_pop, cmd.load_read, $past(cmd.accept && stat.rd_pop), "read without pop")
  // The result slot is empty in the cycle the pop data arrives.
  `DSSM_ASSERT_NXT(a_slot_free_for_pop, cmd.accept && stat.rd_pop, !out_tvalid, "result slot busy on pop")
  // A failed operation carries a zero word.
  `DSSM_ASSERT_IMP(a_fail_zero, out_tvalid && !out_tdata[0], out_tdata[WORD_W:1] == '0, "failed result not zero")

endmodule

>>> sim/dual_stack_shared_memory_tb.sv
// Self-checking testbench for dual_stack_shared_memory: a directed table and then random beats.
// Results are checked against typed row values or a behavioural model of both stacks in this file.
// Depends only on the RTL of the block and on dssm_pkg.
`timescale 1ns / 1ps

module dual_stack_shared_memory_tb;
  import dssm_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int RANDOM_BEATS = 500;
  localparam int MAX_IDLE = 11;
  localparam int MAX_REPORTS = 10;

  // Opcodes that the block does not define. Each one must give a failed result.
  localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] word;
  } stack_result_t;

  // One row of the directed table. The row is sent reps times. Where fixed is set, the
  // result is the one typed in the row. Otherwise the model gives it.
  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [WORD_W-1:0]   value;
    int                  reps;
    bit                  fixed;
    logic                ok;
    logic [WORD_W-1:0]   word;
  } stack_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Model state: the word memory and the two stack pointers.
  logic [WORD_W-1:0] stack_words [STACK_DEPTH];
  int                left_fill;
  int                right_floor;

  stack_result_t     awaited_results [$];
  int                fail_count;
  bit                no_idle;

  stack_row_t stack_rows [17] = '{
    '{OP_LPOP,    32'h0000_0000, 1,  1'b1, 1'b0, 32'h0000_0000},
    '{OP_RPOP,    32'hFFFF_FFFF, 1,  1'b1, 1'b0, 32'h0000_0000},
    '{OP_LPUSH,   32'h8000_0000, 1,  1'b1, 1'b1, 32'h0000_0000},
    '{OP_RPUSH,   32'h7FFF_FFFF, 1,  1'b1, 1'b1, 32'h0000_0000},
    '{OP_LPOP,    32'hFFFF_FFFF, 1,  1'b1, 1'b1, 32'h8000_0000},
    '{OP_RPOP,    32'h0000_0000, 1,  1'b1, 1'b1, 32'h7FFF_FFFF},
    '{OP_SPARE_5, 32'hFFFF_FFFF, 1,  1'b1, 1'b0, 32'h0000_0000},
    '{OP_SPARE_6, 32'h0000_0000, 1,  1'b1, 1'b0, 32'h0000_0000},
    '{OP_SPARE_7, 32'h5A5A_5A5A, 1,  1'b1, 1'b0, 32'h0000_0000},
    // Fill the memory from both ends until the stacks meet.
    '{OP_LPUSH,   32'hFFFF_FFFF, 10, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_RPUSH,   32'h0000_0000, STACK_DEPTH - 10, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_LPUSH,   32'h0000_0001, 1,  1'b1, 1'b0, 32'h0000_0000},
    '{OP_RPUSH,   32'h0000_0002, 1,  1'b1, 1'b0, 32'h0000_0000},
    '{OP_RPOP,    32'h1234_5678, 1,  1'b0, 1'b0, 32'h0000_0000},
    '{OP_LPOP,    32'h0000_0000, 1,  1'b1, 1'b1, 32'hFFFF_FFFF},
    '{OP_CLEAR,   32'hFFFF_FFFF, 1,  1'b1, 1'b1, 32'h0000_0000},
    '{OP_RPOP,    32'h0000_0000, 1,  1'b1, 1'b0, 32'h0000_0000}
  };

  dual_stack_shared_memory #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the model stacks and returns the result it gives.
  function automatic stack_result_t apply_stack_op(logic [OPCODE_W-1:0] op,
                                                   logic [WORD_W-1:0] value);
    stack_result_t res;
    res = '0;
    case (op)
      OP_LPUSH: begin
        if (left_fill < right_floor) begin
          stack_words[left_fill] = value;
          left_fill++;
          res.ok = 1'b1;
        end
      end
      OP_LPOP: begin
        if (left_fill > 0) begin
          left_fill--;
          res.word = stack_words[left_fill];
          res.ok = 1'b1;
        end
      end
      OP_RPUSH: begin
        if (right_floor > left_fill) begin
          right_floor--;
          stack_words[right_floor] = value;
          res.ok = 1'b1;
        end
      end
      OP_RPOP: begin
        if (right_floor < STACK_DEPTH) begin
          res.word = stack_words[right_floor];
          right_floor++;
          res.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        left_fill = 0;
        right_floor = STACK_DEPTH;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offers one beat after a random idle gap (none under no_idle); records its result once it is taken.
  task automatic send_beat(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] value, bit fixed,
                           stack_result_t typed);
    int gap;
    stack_result_t modelled;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - WORD_W - OPCODE_W){1'b0}}, value, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    modelled = apply_stack_op(op, value);
    awaited_results.push_back(fixed ? typed : modelled);
  endtask

  // Holds the input idle until every outstanding result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Picks an opcode for the random part. The fill and drain mixes lean towards pushes or pops so that
  // both full and empty stacks are reached often.
  function automatic logic [OPCODE_W-1:0] pick_op(op_mix_t mix);
    int roll;
    int push_pct;
    bit left_side;
    roll = $urandom_range(0, 99);
    left_side = $urandom_range(0, 1);
    push_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
    if (roll < 2) return OP_CLEAR;
    if (roll == 2) return OP_SPARE_5;
    if (roll == 3) return OP_SPARE_6;
    if (roll == 4) return OP_SPARE_7;
    if ($urandom_range(0, 99) < push_pct) return left_side ? OP_LPUSH : OP_RPUSH;
    return left_side ? OP_LPOP : OP_RPOP;
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: reset, the directed table, then random segments of varied mix.
  initial begin
    op_mix_t mix;
    int seg_left;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    no_idle     = 1'b0;
    fail_count  = 0;
    left_fill   = 0;
    right_floor = STACK_DEPTH;
    seg_left    = 0;
    mix         = MIX_EVEN;
    foreach (stack_words[i]) stack_words[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stack_rows[i]) begin
      for (int k = 0; k < stack_rows[i].reps; k++) begin
        send_beat(stack_rows[i].op, stack_rows[i].value, stack_rows[i].fixed,
                  '{ok: stack_rows[i].ok, word: stack_rows[i].word});
      end
    end
    drain_results();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0:       mix = MIX_FILL;
          1:       mix = MIX_DRAIN;
          default: mix = MIX_EVEN;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) drain_results();
      end
      seg_left--;
      send_beat(pick_op(mix), pick_value(), 1'b0, '0);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: a random stall before each beat, with stretches of none.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Compares each result beat with the oldest outstanding result.
  always @(posedge clk) begin
    stack_result_t want;
    stack_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok   = out_tdata[0];
      got.word = out_tdata[WORD_W:1];
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("Unexpected result beat: ok=%0b word=%08h", got.ok, got.word);
      end else begin
        want = awaited_results.pop_front();
        if (got.ok !== want.ok || got.word !== want.word) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("Result mismatch: expected ok=%0b word=%08h, got ok=%0b word=%08h",
                     want.ok, want.word, got.ok, got.word);
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/dssm_pkg.sv
src/dssm_ram.sv
src/dssm_ctrl.sv
src/dssm_datapath.sv
src/dual_stack_shared_memory.sv
sim/dual_stack_shared_memory_tb.sv
